>>> sv/pvn_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and modular helper for the projective vector normalizer.
// No dependencies.
package pvn_pkg;

    localparam int CW      = 31;             // coordinate / modulus width
    localparam int RANK    = 5;              // coordinates per vector
    localparam int IDXW    = $clog2(RANK);
    localparam int CNTW    = $clog2(CW);
    localparam int AW      = 3;              // APB byte address width

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ZERO  = 2'd1;
    localparam logic [1:0] STATUS_NOINV = 2'd2;

    localparam logic [AW-1:0] ADDR_MODULUS = 3'd0;
    localparam logic [CW-1:0] MODULUS_RST  = 31'd2;

    typedef struct packed {
        logic [CW-1:0] coord_0;
        logic [CW-1:0] coord_1;
        logic [CW-1:0] coord_2;
        logic [CW-1:0] coord_3;
        logic [CW-1:0] coord_4;
    } vec_t;

    typedef struct packed {
        logic [CW-1:0] norm_0;
        logic [CW-1:0] norm_1;
        logic [CW-1:0] norm_2;
        logic [CW-1:0] norm_3;
        logic [CW-1:0] norm_4;
        logic [1:0]    status;
    } res_t;

    typedef struct packed {
        logic          done;
        logic          ok;
        logic [CW-1:0] inv;
    } inv_res_t;

    // (2*acc + b*x) mod p, with acc, x < p
    function automatic logic [CW-1:0] mod_dbl_add(input logic [CW-1:0] acc,
                                                  input logic          b,
                                                  input logic [CW-1:0] x,
                                                  input logic [CW-1:0] p);
        logic [CW:0] s;
        logic [CW:0] t;
        s = {acc, 1'b0};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        t = s + (b ? {1'b0, x} : {(CW+1){1'b0}});
        if (t >= {1'b0, p})
            t = t - {1'b0, p};
        return t[CW-1:0];
    endfunction

endpackage

>>> sv/pvn_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial modular multiplier: x * y mod p, one bit of y per cycle, MSB first.
// Depends on pvn_pkg.
module pvn_mulmod
    import pvn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] x,
    input  logic [CW-1:0] y,
    input  logic [CW-1:0] p,
    output logic          done,
    output logic [CW-1:0] prod
);

    logic [CW-1:0]   acc_reg, acc_next;
    logic [CW-1:0]   y_reg, y_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            y_next    = y;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = mod_dbl_add(acc_reg, y_reg[CW-1], x, p);
            y_next   = {y_reg[CW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(CW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> sv/pvn_inv.sv
`timescale 1ns / 1ps
// Extended Euclid modular inverse with shift-subtract division, one step per cycle.
// Depends on pvn_pkg.
module pvn_inv
    import pvn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] a,      // already reduced below p
    input  logic [CW-1:0] p,
    output inv_res_t      res
);

    localparam logic [2:0] E_IDLE  = 3'd0;
    localparam logic [2:0] E_CHECK = 3'd1;
    localparam logic [2:0] E_UP    = 3'd2;
    localparam logic [2:0] E_DOWN  = 3'd3;
    localparam logic [2:0] E_UPD   = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   r0_reg, r0_next, r1_reg, r1_next;
    logic [CW-1:0]   t0_reg, t0_next, t1_reg, t1_next;
    logic [CW-1:0]   d_reg, d_next, qt_reg, qt_next;
    logic [CNTW-1:0] s_reg, s_next;
    inv_res_t        res_reg, res_next;
    logic            ge;

    assign ge = (r0_reg >= d_reg);

    always_comb
    begin
        state_next = state_reg;
        r0_next = r0_reg;
        r1_next = r1_reg;
        t0_next = t0_reg;
        t1_next = t1_reg;
        d_next  = d_reg;
        qt_next = qt_reg;
        s_next  = s_reg;
        res_next = res_reg;
        res_next.done = 1'b0;
        case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    r0_next = p;
                    r1_next = a;
                    t0_next = '0;
                    t1_next = CW'(1);
                    state_next = E_CHECK;
                end
            end
            E_CHECK:
            begin
                if (r1_reg == '0)
                begin
                    res_next.done = 1'b1;
                    res_next.ok   = (r0_reg == CW'(1));
                    res_next.inv  = t0_reg;
                    state_next = E_IDLE;
                end
                else
                begin
                    d_next  = r1_reg;
                    s_next  = '0;
                    qt_next = '0;
                    state_next = E_UP;
                end
            end
            E_UP:
            begin
                // align divisor under the dividend
                if (!d_reg[CW-1] && ({d_reg[CW-2:0], 1'b0} <= r0_reg))
                begin
                    d_next = {d_reg[CW-2:0], 1'b0};
                    s_next = s_reg + 1'b1;
                end
                else
                    state_next = E_DOWN;
            end
            E_DOWN:
            begin
                if (ge)
                    r0_next = r0_reg - d_reg;
                qt_next = mod_dbl_add(qt_reg, ge, t1_reg, p);
                d_next  = {1'b0, d_reg[CW-1:1]};
                if (s_reg == '0)
                    state_next = E_UPD;
                else
                    s_next = s_reg - 1'b1;
            end
            E_UPD:
            begin
                // r0 now holds the remainder
                r0_next = r1_reg;
                r1_next = r0_reg;
                t0_next = t1_reg;
                if (t0_reg >= qt_reg)
                    t1_next = t0_reg - qt_reg;
                else
                    t1_next = t0_reg + (p - qt_reg);
                state_next = E_CHECK;
            end
            default:
                state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
        t0_reg <= t0_next;
        t1_reg <= t1_next;
        d_reg  <= d_next;
        qt_reg <= qt_next;
        s_reg  <= s_next;
    end

    assign res = res_reg;

endmodule

>>> sv/projective_vector_normalize_mod_p_unit.sv
`timescale 1ns / 1ps
// Top level: APB modulus register, sequencer, input capture and result register.
// Depends on pvn_pkg, pvn_mulmod, pvn_inv.
//
// Usage:
//   Input channel vec/vec_valid/vec_stall carries one vector of RANK coordinates.
//   Output channel res/res_valid/res_stall returns the vector scaled so the first
//   nonzero coordinate is 1, plus a status (ok, all-zero, no inverse).
//   The modulus is written over APB at byte address 0 while the block is idle.
//   One item at a time: vec_stall is high from acceptance until the sequencer
//   is back to idle. All-zero vectors and a modulus below two go straight to
//   the output state. Otherwise: the pivot residue in the serial multiplier,
//   then the Euclid loop (each step checks, aligns the divisor, shift-subtracts
//   one quotient bit at a time and updates), then RANK serial multiplies.
//   The result sits in an output register; a new item is accepted while it waits.
//   If the receiver stalls, the finished result is held in the sequencer until
//   the output register frees up.
//   Reset clears the modulus to 2 and drops res_valid.
module projective_vector_normalize_mod_p_unit
    import pvn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          vec_valid,
    output logic          vec_stall,
    input  vec_t          vec,
    output logic          res_valid,
    input  logic          res_stall,
    output res_t          res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RES  = 3'd1;
    localparam logic [2:0] S_INV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [CW-1:0]   modulus_reg;
    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   vec_reg [RANK];
    logic [CW-1:0]   prod_reg [RANK];
    logic [CW-1:0]   inv_reg;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic [1:0]      status_reg, status_next;
    logic            res_valid_reg;
    res_t            res_reg;

    logic [CW-1:0]   cin [RANK];
    logic [CW-1:0]   pivot_val;
    logic            any_nz;
    logic            accept;

    logic            mul_start;
    logic [CW-1:0]   mul_x, mul_y, mul_prod;
    logic            mul_done;
    logic            inv_start;
    inv_res_t        inv_res;
    logic            load_out;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODULUS) ? {1'b0, modulus_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MODULUS_RST;
        else if (psel && penable && pwrite && !paddr[AW-1])
            modulus_reg <= pwdata[CW-1:0];
    end

    assign cin[0] = vec.coord_0;
    assign cin[1] = vec.coord_1;
    assign cin[2] = vec.coord_2;
    assign cin[3] = vec.coord_3;
    assign cin[4] = vec.coord_4;

    always_comb
    begin
        pivot_val = '0;
        any_nz    = 1'b0;
        for (int i = RANK - 1; i >= 0; i--)
        begin
            if (cin[i] != '0)
            begin
                pivot_val = cin[i];
                any_nz    = 1'b1;
            end
        end
    end

    assign vec_stall = (state_reg != S_IDLE);
    assign accept    = vec_valid && !vec_stall;
    assign load_out  = (state_reg == S_OUT) && (!res_valid_reg || !res_stall);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        mul_start   = 1'b0;
        mul_y       = pivot_val;
        inv_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (modulus_reg < CW'(2))
                    begin
                        status_next = STATUS_NOINV;
                        state_next  = S_OUT;
                    end
                    else if (!any_nz)
                    begin
                        status_next = STATUS_ZERO;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = S_RES;
                    end
                end
            end
            S_RES:
            begin
                if (mul_done)
                begin
                    inv_start  = 1'b1;
                    state_next = S_INV;
                end
            end
            S_INV:
            begin
                mul_y = vec_reg[0];
                if (inv_res.done)
                begin
                    if (!inv_res.ok)
                    begin
                        status_next = STATUS_NOINV;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        mul_start  = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                mul_y = vec_reg[IDXW'((RANK - 1 > idx_reg) ? idx_reg + 1'b1 : idx_reg)];
                if (mul_done)
                begin
                    if (idx_reg == IDXW'(RANK - 1))
                    begin
                        status_next = STATUS_OK;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        mul_start = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // x is 1 while reducing the pivot, the inverse while scaling
    assign mul_x = (state_reg == S_MUL || state_reg == S_INV) ? inv_res.inv : CW'(1);

    pvn_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     ((state_reg == S_MUL) ? inv_reg : mul_x),
        .y     (mul_y),
        .p     (modulus_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pvn_inv u_inv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (inv_start),
        .a     (mul_prod),
        .p     (modulus_reg),
        .res   (inv_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            status_reg    <= STATUS_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < RANK; i++)
                vec_reg[i] <= cin[i];
        end
        if (state_reg == S_INV && inv_res.done)
            inv_reg <= inv_res.inv;
        if (state_reg == S_MUL && mul_done)
            prod_reg[idx_reg] <= mul_prod;
        if (load_out)
        begin
            res_reg.status <= status_reg;
            res_reg.norm_0 <= (status_reg == STATUS_OK) ? prod_reg[0] : '0;
            res_reg.norm_1 <= (status_reg == STATUS_OK) ? prod_reg[1] : '0;
            res_reg.norm_2 <= (status_reg == STATUS_OK) ? prod_reg[2] : '0;
            res_reg.norm_3 <= (status_reg == STATUS_OK) ? prod_reg[3] : '0;
            res_reg.norm_4 <= (status_reg == STATUS_OK) ? prod_reg[4] : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> sv/pvn_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the projective vector normalizer, bound to the top level.
// Depends on pvn_pkg.
module pvn_checker
    import pvn_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic vec_valid,
    input logic vec_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // one item at a time: stall rises right after an accepted item
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        vec_valid && !vec_stall |=> vec_stall)
        else $error("second item taken while busy");

    // failures carry zero coordinates
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != STATUS_OK |->
            res.norm_0 == '0 && res.norm_1 == '0 && res.norm_2 == '0 &&
            res.norm_3 == '0 && res.norm_4 == '0)
        else $error("nonzero coordinates on failure");

    // success leaves a pivot of one
    a_pivot_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == STATUS_OK |->
            res.norm_0 == CW'(1) || res.norm_1 == CW'(1) || res.norm_2 == CW'(1) ||
            res.norm_3 == CW'(1) || res.norm_4 == CW'(1))
        else $error("no unit pivot in result");

endmodule

bind projective_vector_normalize_mod_p_unit pvn_checker u_pvn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for projective_vector_normalize_mod_p_unit: directed table, then random
// vectors over several moduli, results checked against typed rows or a local normalizer.
// Depends on pvn_pkg and the RTL of the unit.
module testbench;
    import pvn_pkg::*;

    localparam logic [AW-1:0] ADDR_UNUSED = 3'd4;
    localparam logic [CW-1:0] PMAX = 31'h7FFFFFFF;

    logic          clk;
    logic          rst_n;
    logic          psel, penable, pwrite;
    logic [AW-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          vec_valid, vec_stall;
    vec_t          vec;
    logic          res_valid, res_stall;
    res_t          res;

    projective_vector_normalize_mod_p_unit DUT (.*);

    res_t          pending_res[$];
    logic [CW-1:0] cur_mod;
    logic [31:0]   last_wr;
    int            errors;
    bit            no_idle;
    int            stall_left, run_left;
    bit            stalling;

    typedef struct {
        logic [31:0] modv;
        vec_t        v;
        bit          typed;
        res_t        e;
    } row_t;

    localparam res_t NOINV_RES = '{0, 0, 0, 0, 0, STATUS_NOINV};
    localparam res_t ZERO_RES  = '{0, 0, 0, 0, 0, STATUS_ZERO};

    row_t dir_tab[18] = '{
        '{32'd2, '{0, 0, 0, 0, 0}, 1, ZERO_RES},
        '{32'd2, '{1, 1, 1, 1, 1}, 1, '{1, 1, 1, 1, 1, STATUS_OK}},
        '{32'd2, '{0, 0, 0, 0, 1}, 1, '{0, 0, 0, 0, 1, STATUS_OK}},
        '{32'd7, '{3, 5, 6, 0, 1}, 0, ZERO_RES},
        '{32'd7, '{0, 0, 4, 2, 6}, 0, ZERO_RES},
        '{32'd7, '{7, 1, 2, 3, 4}, 1, NOINV_RES},
        '{32'd7, '{9, 100, 0, PMAX, 13}, 0, ZERO_RES},
        '{32'd7, '{0, 0, 0, 0, 0}, 1, ZERO_RES},
        '{32'h7FFFFFFF, '{PMAX - 1, PMAX - 1, PMAX - 1, PMAX - 1, PMAX - 1}, 1,
          '{1, 1, 1, 1, 1, STATUS_OK}},
        '{32'h7FFFFFFF, '{PMAX, 1, 2, 3, 4}, 1, NOINV_RES},
        '{32'h7FFFFFFF, '{0, 12345, PMAX - 1, 1, 0}, 0, ZERO_RES},
        '{32'h7FFFFFFF, '{1, PMAX - 1, 0, 1, PMAX - 1}, 1,
          '{1, PMAX - 1, 0, 1, PMAX - 1, STATUS_OK}},
        '{32'd15, '{5, 1, 2, 3, 4}, 1, NOINV_RES},
        '{32'd15, '{0, 2, 7, 14, 9}, 0, ZERO_RES},
        '{32'd0, '{1, 2, 3, 4, 5}, 1, NOINV_RES},
        '{32'd1, '{0, 0, 0, 0, 0}, 1, NOINV_RES},
        '{32'h80000005, '{0, 0, 0, 3, 4}, 0, ZERO_RES},
        // pivot equals the modulus itself
        '{32'h7FFFFFFE, '{0, 0, 0, 0, PMAX - 1}, 1, NOINV_RES}
    };

    function automatic res_t normalize(vec_t v, logic [CW-1:0] p);
        logic [63:0] c[RANK];
        logic [63:0] r0, r1, r2, t0, t1, t2, q, inv, pp;
        int          piv;
        res_t        r;
        c[0] = v.coord_0; c[1] = v.coord_1; c[2] = v.coord_2;
        c[3] = v.coord_3; c[4] = v.coord_4;
        pp = p;
        if (pp < 2)
            return NOINV_RES;
        piv = RANK;
        for (int i = RANK - 1; i >= 0; i--)
            if (c[i] != 0)
                piv = i;
        if (piv == RANK)
            return ZERO_RES;
        r0 = pp; r1 = c[piv] % pp; t0 = 0; t1 = 1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            t2 = (t0 + pp - (q * t1) % pp) % pp;
            r0 = r1; r1 = r2; t0 = t1; t1 = t2;
        end
        if (r0 != 1)
            return NOINV_RES;
        inv = t0 % pp;
        for (int i = 0; i < RANK; i++)
            c[i] = (inv * (c[i] % pp)) % pp;
        r.norm_0 = c[0][CW-1:0]; r.norm_1 = c[1][CW-1:0]; r.norm_2 = c[2][CW-1:0];
        r.norm_3 = c[3][CW-1:0]; r.norm_4 = c[4][CW-1:0];
        r.status = STATUS_OK;
        return r;
    endfunction

    function automatic int pick_gap();
        if (no_idle)
            return 1;
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    endfunction

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // receiver backpressure: alternating runs and stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stalling   = 1'b0;
            stall_left = 0;
            run_left   = 0;
        end
        else if (no_idle)
            res_stall <= 1'b0;
        else
        begin
            if (stalling && stall_left > 0)
                stall_left--;
            else if (!stalling && run_left > 0)
                run_left--;
            else
            begin
                stalling = !stalling;
                if (stalling)
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                            : $urandom_range(20, 300);
                else
                    run_left = $urandom_range(1, 40);
            end
            res_stall <= stalling;
        end
    end

    task automatic check_field(string name, logic [CW-1:0] e, logic [CW-1:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_res.size() == 0)
            begin
                $display("%0t: unexpected item, actual %p", $time, res);
                errors++;
            end
            else
            begin
                e = pending_res.pop_front();
                check_field("norm_0", e.norm_0, res.norm_0);
                check_field("norm_1", e.norm_1, res.norm_1);
                check_field("norm_2", e.norm_2, res.norm_2);
                check_field("norm_3", e.norm_3, res.norm_3);
                check_field("norm_4", e.norm_4, res.norm_4);
                check_field("status", CW'(e.status), CW'(res.status));
            end
        end
    end

    task automatic wait_idle();
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(logic [AW-1:0] a, logic [31:0] d);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == ADDR_MODULUS)
            cur_mod = d[CW-1:0];
    endtask

    task automatic set_modulus(logic [31:0] d);
        wait_idle();
        apb_write(ADDR_MODULUS, d);
        last_wr = d;
    endtask

    // valid is low on entry; lowered again at the accepting edge
    task automatic send_vec(vec_t v, bit typed, res_t e);
        repeat (pick_gap()) @(posedge clk);
        vec <= v;
        vec_valid <= 1'b1;
        do
            @(posedge clk);
        while (vec_stall);
        pending_res.push_back(typed ? e : normalize(v, cur_mod));
        vec_valid <= 1'b0;
    endtask

    function automatic logic [CW-1:0] rand_coord(logic [CW-1:0] p);
        int k;
        k = $urandom_range(0, 19);
        if (p < 2 || k == 0)
            return CW'($urandom());
        if (k == 1)
            return p - 1;
        if (k == 2)
            return 1;
        return CW'($urandom() % p);
    endfunction

    task automatic random_phase(logic [31:0] d, int n, bit hold_off);
        vec_t          v;
        logic [CW-1:0] c[RANK];
        int            z;
        set_modulus(d);
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < RANK; i++)
                c[i] = rand_coord(cur_mod);
            z = ($urandom_range(0, 3) == 0) ? $urandom_range(1, RANK) : 0;
            for (int i = 0; i < z; i++)
                c[i] = '0;
            v = '{c[0], c[1], c[2], c[3], c[4]};
            if (hold_off)
                while (pending_res.size() != 0)
                    @(posedge clk);
            send_vec(v, 1'b0, ZERO_RES);
        end
    endtask

    initial
    begin
        logic [31:0] mods[12];
        errors = 0;
        no_idle = 1'b0;
        cur_mod = MODULUS_RST;
        last_wr = {1'b0, MODULUS_RST};
        rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        vec_valid <= 1'b0; vec <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write outside the register map must leave the modulus alone
        apb_write(ADDR_UNUSED, 32'd11);
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].modv != last_wr)
                set_modulus(dir_tab[i].modv);
            send_vec(dir_tab[i].v, dir_tab[i].typed, dir_tab[i].e);
        end

        mods = '{32'h7FFFFFFF, 32'd2, 32'd3, 32'd65521, 32'd1000003, 32'd2147483629,
                 32'd15, 32'h7FFFFFFE, 32'd0, 32'd1, $urandom(), $urandom()};
        foreach (mods[i])
        begin
            no_idle = (i == 4);
            random_phase(mods[i], (i == 8 || i == 9) ? 40 : 140, i == 2);
        end
        no_idle = 1'b0;
        random_phase($urandom() | 32'h40000000, 60, 1'b0);

        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
